// ===== src/mbfr_pkg.sv =====
package mbfr_pkg;

  // Buffer geometry
  localparam int BUFFER_BITS    = 64;
  localparam int MAX_FIELD_BITS = 32;
  localparam int BYTE_BITS      = 8;
  localparam int VALUE_W        = 32;
  localparam int KIND_W         = 3;
  localparam int COUNT_W        = 6;
  localparam int HELD_W         = $clog2(BUFFER_BITS + 1);
  // Width for comparing bit counts against the held count
  localparam int CMP_W          = ((HELD_W > COUNT_W) ? HELD_W : COUNT_W) + 1;

  // Transaction kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH      = 3'd0,
    KIND_UBITS     = 3'd1,
    KIND_SBITS     = 3'd2,
    KIND_ALIGN     = 3'd3,
    KIND_LE_UBYTES = 3'd4,
    KIND_LE_SBYTES = 3'd5
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_WIDE  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [BYTE_BITS-1:0] byte_in;
    logic [COUNT_W-1:0]   count;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } rsp_t;

  // Outcome of one transaction against the current buffer state
  typedef struct packed {
    logic                   emit;
    rsp_t                   rsp;
    logic [BUFFER_BITS-1:0] buffer;
    logic [HELD_W-1:0]      held;
  } step_t;

endpackage

// ===== src/mbfr_extract.sv =====
module mbfr_extract
  import mbfr_pkg::*;
(
  input  logic [BUFFER_BITS-1:0] buffer,
  input  logic [HELD_W-1:0]      held,
  input  req_t                   req,
  output step_t                  step
);

  logic [CMP_W-1:0]       held_w;
  logic [CMP_W-1:0]       count_w;
  logic [CMP_W-1:0]       push_end;
  logic [HELD_W-1:0]      aligned;
  logic [HELD_W-1:0]      byte_bits;
  logic [HELD_W-1:0]      bit_pos;
  logic [HELD_W-1:0]      byte_pos;
  logic [BUFFER_BITS-1:0] bit_shifted;
  logic [BUFFER_BITS-1:0] byte_shifted;
  logic [VALUE_W-1:0]     field_mask;
  logic [VALUE_W-1:0]     bit_field;
  logic [VALUE_W-1:0]     word;
  logic [VALUE_W-1:0]     le_value;
  logic                   sign_bit;
  logic                   byte_count_ok;

  // Shared arithmetic on the held count
  assign held_w    = CMP_W'(held);
  assign count_w   = CMP_W'(req.count);
  assign push_end  = held_w + CMP_W'(BYTE_BITS);
  assign aligned   = held & ~HELD_W'(BYTE_BITS - 1);
  assign byte_bits = HELD_W'({req.count, 3'b000});
  assign bit_pos   = held - HELD_W'(req.count);
  assign byte_pos  = aligned - byte_bits;

  // Bit field: oldest bits sit at the top of the held window
  assign bit_shifted = buffer >> bit_pos;
  assign field_mask  = ~({VALUE_W{1'b1}} << req.count);
  assign bit_field   = bit_shifted[VALUE_W-1:0] & field_mask;
  assign sign_bit    = (req.count != '0) && bit_field[5'(req.count - COUNT_W'(1))];

  // Byte read: big-endian word first, then byte-reversed
  assign byte_shifted  = buffer >> byte_pos;
  assign word          = byte_shifted[VALUE_W-1:0];
  assign byte_count_ok = (req.count == COUNT_W'(1)) || (req.count == COUNT_W'(2)) ||
                         (req.count == COUNT_W'(4));

  always_comb begin
    le_value = '0;
    if (req.count == COUNT_W'(1)) begin
      le_value = {24'd0, word[7:0]};
      if (req.kind == KIND_LE_SBYTES && word[7]) le_value[31:8] = '1;
    end else if (req.count == COUNT_W'(2)) begin
      le_value = {16'd0, word[7:0], word[15:8]};
      if (req.kind == KIND_LE_SBYTES && word[7]) le_value[31:16] = '1;
    end else begin
      le_value = {word[7:0], word[15:8], word[23:16], word[31:24]};
    end
  end

  // Per-kind outcome
  always_comb begin
    step.emit       = 1'b1;
    step.rsp.value  = '0;
    step.rsp.status = ST_OK;
    step.buffer     = buffer;
    step.held       = held;
    unique case (req.kind)
      KIND_PUSH: begin
        if (push_end > CMP_W'(BUFFER_BITS)) begin
          step.rsp.status = ST_FULL;
        end else begin
          step.emit   = 1'b0;
          step.buffer = {buffer[BUFFER_BITS-BYTE_BITS-1:0], req.byte_in};
          step.held   = held + HELD_W'(BYTE_BITS);
        end
      end
      KIND_UBITS, KIND_SBITS: begin
        if (count_w > CMP_W'(MAX_FIELD_BITS)) begin
          step.rsp.status = ST_TOO_WIDE;
        end else if (count_w > held_w) begin
          step.rsp.status = ST_UNDERFLOW;
        end else begin
          step.held      = bit_pos;
          step.rsp.value = bit_field;
          if (req.kind == KIND_SBITS && sign_bit) step.rsp.value = bit_field | ~field_mask;
        end
      end
      KIND_ALIGN: begin
        step.held = aligned;
      end
      KIND_LE_UBYTES, KIND_LE_SBYTES: begin
        if (!byte_count_ok) begin
          step.rsp.status = ST_TOO_WIDE;
        end else if (aligned < byte_bits) begin
          step.rsp.status = ST_UNDERFLOW;
        end else begin
          step.held      = byte_pos;
          step.rsp.value = le_value;
        end
      end
      default: begin
        // unused kinds: no result, no state change
        step.emit = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/msb_first_bit_field_reader.sv =====
// MSB-first bit field reader. Bytes pushed on the request channel are
// appended to a 64-bit buffer; field requests extract 0..32 bits MSB-first
// (unsigned or sign-extended), align to a byte boundary, or read 1, 2 or 4
// aligned bytes little-endian. Pushes that fit produce no response; every
// other valid kind produces exactly one response with a status (ok, too
// wide, underflow, buffer full). Kinds 6 and 7 are ignored. The block
// sustains one transaction per cycle while the response channel is not
// stalled: a request is registered, resolved by a barrel shift over the
// buffer with the held count fed back to the next request, and its
// response is registered, so a response becomes valid once its request
// has passed the request register and then the response register.
module msb_first_bit_field_reader
  import mbfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic                   s1_valid;
  req_t                   s1_req;
  logic [BUFFER_BITS-1:0] buffer;
  logic [HELD_W-1:0]      held;
  step_t                  step;
  logic                   fire;

  mbfr_extract u_extract (
    .buffer (buffer),
    .held   (held),
    .req    (s1_req),
    .step   (step)
  );

  // Resolve the staged request when its response slot is free or it emits no response
  assign fire      = s1_valid && (!step.emit || !rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || fire;

  // Request stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
    if (req_valid && req_ready) s1_req <= req;
  end

  // Buffer state
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer <= '0;
      held   <= '0;
    end else if (fire) begin
      buffer <= step.buffer;
      held   <= step.held;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_ready) rsp_valid <= 1'b0;
      if (fire && step.emit) rsp_valid <= 1'b1;
    end
    if (fire && step.emit) rsp <= step.rsp;
  end

endmodule
